// ===== sv/modular_power_and_divide_top_macros.svh =====
// Assertion macros for the modular power and divide block.
`ifndef MODULAR_POWER_AND_DIVIDE_TOP_MACROS_SVH
`define MODULAR_POWER_AND_DIVIDE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define MPD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modular_power_and_divide: check failed");

// Next-cycle implication, disabled while reset is high.
`define MPD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modular_power_and_divide: check failed");

`else

`define MPD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define MPD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== sv/mpd_pkg.sv =====
// Package with constants and types of the modular power and divide block.
`default_nettype none
package mpd_pkg;

  localparam logic [31:0] MODULUS_RESET = 32'd998244353;

  localparam logic OP_POW = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RED  = 6'b000010,
    S_STEP = 6'b000100,
    S_MA   = 6'b001000,
    S_MS   = 6'b010000,
    S_FIN  = 6'b100000
  } mpd_state_t;

endpackage
`default_nettype wire

// ===== sv/mpd_modmul.sv =====
// Bit-serial interleaved modular multiplier: prod = x * y mod m, x below m.
`default_nettype none
module mpd_modmul #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] x,
  input  logic [W-1:0] y,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int CW = $clog2(W);

  logic          run;
  logic [CW-1:0] cnt;
  logic [W-1:0]  acc;
  logic [W-1:0]  xr;
  logic [W-1:0]  yr;
  logic [W-1:0]  mr;

  logic [W+1:0]  t;
  logic [W+1:0]  m1;
  logic [W+1:0]  m2;
  logic [W+1:0]  t1;
  logic [W+1:0]  t2;
  logic [W-1:0]  red;

  // 2*acc + bit*x stays below 3m: subtract m or 2m once.
  always_comb begin
    t   = {1'b0, acc, 1'b0} + (yr[W-1] ? {2'b00, xr} : '0);
    m1  = {2'b00, mr};
    m2  = {1'b0, mr, 1'b0};
    t1  = t - m1;
    t2  = t - m2;
    if (t >= m2) begin
      red = t2[W-1:0];
    end else if (t >= m1) begin
      red = t1[W-1:0];
    end else begin
      red = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      xr  <= x;
      yr  <= y;
      mr  <= m;
    end else if (run) begin
      acc <= red;
      yr  <= {yr[W-2:0], 1'b0};
    end
  end

  assign prod = acc;

endmodule
`default_nettype wire

// ===== sv/modular_power_and_divide_top.sv =====
// Top level of the modular power and divide block: sequencer around one modular multiplier.
`default_nettype none
`include "modular_power_and_divide_top_macros.svh"
// Raise a to b mod m (opcode 0) or form a * b^(m-2) mod m (opcode 1), with m
// the modulus register. Write the modulus only while busy is low and no item
// is in flight. Start an item by raising start while busy is low; busy then
// stays high until the answer appears. The answer shows on result, marked by
// done high for exactly one cycle; the receiver cannot stall it, so capture it in
// that cycle. Every product goes through one bit-serial modular multiplier
// (a launch, a step for each bit of the second factor, then a handoff), and
// each exponent bit adds a pass through the step state. An item takes one
// reduction product, then one product per set exponent bit plus a square for
// every bit below the top one, and for a divide one closing product: at most
// 2*DATA_WIDTH products. A modulus below two answers in the cycle after the
// start, with busy staying low; a divisor that is zero mod m answers after the
// reduction product alone. Both give result zero.
module modular_power_and_divide_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  opcode,
  input  logic [DATA_WIDTH-1:0] operand_a,
  input  logic [DATA_WIDTH-1:0] operand_b,
  input  logic                  modulus_we,
  input  logic [DATA_WIDTH-1:0] modulus_wdata,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  import mpd_pkg::*;

  localparam int W = DATA_WIDTH;
  localparam logic [W-1:0] MOD_RST = MODULUS_RESET[W-1:0];
  localparam logic [W-1:0] ONE     = W'(1);
  localparam logic [W-1:0] TWO     = W'(2);

  mpd_state_t   state;
  logic [W-1:0] modulus;   // configuration register
  logic [W-1:0] m_lat;     // modulus held for the item in flight
  logic         op;
  logic [W-1:0] a_lat;
  logic [W-1:0] expo;
  logic [W-1:0] base;
  logic [W-1:0] acc;

  // Multiplier launch word and returned product.
  logic         mul_go;
  logic [W-1:0] mul_x;
  logic [W-1:0] mul_y;
  logic         mul_done;
  logic [W-1:0] mul_prod;

  mpd_modmul #(.W(W)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (mul_go),
    .x    (mul_x),
    .y    (mul_y),
    .m    (m_lat),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign busy = (state != S_IDLE);

  // Modulus register: the user must write it only while idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RST;
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  // Control state of the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mul_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      done   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (modulus < TWO) begin
              done <= 1'b1;          // degenerate modulus: answer zero
            end else begin
              mul_go <= 1'b1;        // reduce the base: 1 * src mod m
              state  <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mul_done) begin
            if (op == OP_DIV && mul_prod == '0) begin
              done  <= 1'b1;         // divisor zero mod m: answer zero
              state <= S_IDLE;
            end else begin
              state <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (expo == '0) begin
            if (op == OP_DIV) begin
              mul_go <= 1'b1;        // close the divide: inverse * a
              state  <= S_FIN;
            end else begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            mul_go <= 1'b1;
            state  <= expo[0] ? S_MA : S_MS;
          end
        end
        S_MA: begin
          if (mul_done) begin
            if (expo[W-1:1] == '0) begin
              state <= S_STEP;       // no higher bits: skip the last square
            end else begin
              mul_go <= 1'b1;
              state  <= S_MS;
            end
          end
        end
        S_MS: begin
          if (mul_done) begin
            state <= S_STEP;
          end
        end
        S_FIN: begin
          if (mul_done) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers: operands, multiplier inputs, exponent, base, accumulator, result.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          op     <= opcode;
          a_lat  <= operand_a;
          m_lat  <= modulus;
          acc    <= ONE;
          result <= '0;
          mul_x  <= ONE;
          mul_y  <= (opcode == OP_DIV) ? operand_b : operand_a;
          expo   <= (opcode == OP_DIV) ? (modulus - TWO) : operand_b;
        end
      end
      S_RED: begin
        if (mul_done) begin
          base   <= mul_prod;
          result <= '0;
        end
      end
      S_STEP: begin
        if (expo == '0) begin
          result <= acc;
          mul_x  <= acc;
          mul_y  <= a_lat;
        end else if (expo[0]) begin
          mul_x <= acc;
          mul_y <= base;
        end else begin
          mul_x <= base;
          mul_y <= base;
        end
      end
      S_MA: begin
        if (mul_done) begin
          acc <= mul_prod;
          if (expo[W-1:1] == '0) begin
            expo <= '0;
          end else begin
            mul_x <= base;
            mul_y <= base;
          end
        end
      end
      S_MS: begin
        if (mul_done) begin
          base <= mul_prod;
          expo <= {1'b0, expo[W-1:1]};
        end
      end
      S_FIN: begin
        if (mul_done) begin
          result <= mul_prod;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  // Answer is reduced below the modulus of its item when that modulus is two or more.
  `MPD_ASSERT_SAME(a_result_reduced, clk, rst, done && (m_lat >= TWO), result < m_lat)
  // An accepted item makes the block busy, or answers at once, in the next cycle.
  `MPD_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy || done)
  // The answer strobe comes only with the block back at rest.
  `MPD_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  // A product returns only while the sequencer waits for one.
  `MPD_ASSERT_SAME(a_mul_wait, clk, rst, mul_done,
    (state == S_RED) || (state == S_MA) || (state == S_MS) || (state == S_FIN))

endmodule
`default_nettype wire

// ===== bench/tb_modular_power_and_divide_top.sv =====
// Self-checking testbench for the modular power and divide block.
`default_nettype none
module tb_modular_power_and_divide_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mpd_pkg::*;

  localparam int W = 32;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] PRIME_TOP = 32'd4294967291;   // largest 32-bit prime
  localparam int BATCHES = 10;
  localparam int WORDS_PER_BATCH = 125;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam bit KNOWN = 1'b1;     // answer typed into the table
  localparam bit PREDICT = 1'b0;   // answer taken from the predictor

  // One row of the directed table: modulus in force, the word, and an
  // optional answer that can be read off by eye.
  typedef struct packed {
    logic [W-1:0] modulus;
    logic         op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         has_answer;
    logic [W-1:0] answer;
  } directed_word_t;

  logic         clk;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  logic         opcode = OP_POW;
  logic [W-1:0] operand_a = '0;
  logic [W-1:0] operand_b = '0;
  logic         modulus_we = 1'b0;
  logic [W-1:0] modulus_wdata = '0;
  logic         busy;
  logic         done;
  logic [W-1:0] result;

  logic [W-1:0]   modulus_shadow = MODULUS_RESET;
  logic [W-1:0]   pending_answers [$];
  logic [W-1:0]   answer_due;
  directed_word_t directed_words [$];
  int             error_count = 0;
  int             idle_pct = 0;

  modular_power_and_divide_top #(.DATA_WIDTH(W)) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .operand_a    (operand_a),
    .operand_b    (operand_b),
    .modulus_we   (modulus_we),
    .modulus_wdata(modulus_wdata),
    .done         (done),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Right-to-left square and multiply; every product is formed at 64 bits
  // from factors below 2^32, so nothing overflows before the reduction.
  function automatic logic [W-1:0] mod_pow(input logic [W-1:0] base,
                                           input logic [W-1:0] expo,
                                           input logic [W-1:0] m);
    logic [63:0]  acc;
    logic [63:0]  sq;
    logic [W-1:0] e;
    acc = 64'd1 % m;
    sq  = {32'd0, base % m};
    e   = expo;
    while (e != '0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e  = e >> 1;
    end
    return acc[W-1:0];
  endfunction

  // Answer of one word under modulus m: power, or division by the Fermat inverse.
  function automatic logic [W-1:0] predict_result(input logic op, input logic [W-1:0] a,
                                                  input logic [W-1:0] b,
                                                  input logic [W-1:0] m);
    logic [63:0] prod;
    if (m < 2) return '0;
    if (op == OP_POW) return mod_pow(a, b, m);
    if (b % m == '0) return '0;
    prod = ({32'd0, a % m} * {32'd0, mod_pow(b, m - 2, m)}) % {32'd0, m};
    return prod[W-1:0];
  endfunction

  task automatic add_directed(input logic [W-1:0] m, input logic op,
                              input logic [W-1:0] a, input logic [W-1:0] b,
                              input bit has_answer, input logic [W-1:0] answer);
    directed_word_t row;
    row.modulus    = m;
    row.op         = op;
    row.a          = a;
    row.b          = b;
    row.has_answer = has_answer;
    row.answer     = answer;
    directed_words.push_back(row);
  endtask

  // Idle at random, present the word, hold it until busy is low at an edge,
  // then log what the block owes for it.
  task automatic send_word(input logic op, input logic [W-1:0] a, input logic [W-1:0] b,
                           input bit has_answer, input logic [W-1:0] answer);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(has_answer ? answer : predict_result(op, a, b, modulus_shadow));
  endtask

  // Drop start and wait until every owed answer is back and the block is idle.
  task automatic settle_outstanding();
    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0 || busy) @(posedge clk);
  endtask

  // Write the modulus only once the block has gone quiet.
  task automatic write_modulus(input logic [W-1:0] value);
    settle_outstanding();
    @(negedge clk);
    modulus_we    <= 1'b1;
    modulus_wdata <= value;
    @(negedge clk);
    modulus_we     <= 1'b0;
    modulus_shadow  = value;
  endtask

  // Full-range operands half the time, the rest aimed at small values, values
  // around the modulus, exact multiples of it and a set top bit.
  task automatic send_random_word(input logic [W-1:0] m);
    logic         op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic [W-1:0] k_max;
    op = $urandom_range(1) ? OP_DIV : OP_POW;
    a  = $urandom;
    b  = $urandom;
    case ($urandom_range(9))
      5: a = $urandom_range(3);
      6: b = $urandom_range(3);
      7: a = m + $urandom_range(2) - 1;
      8: begin
        k_max = ALL_ONES / m;
        b = m * $urandom_range(k_max);
      end
      9: b = {1'b1, b[W-2:0]};
      default: ;
    endcase
    send_word(op, a, b, PREDICT, '0);
  endtask

  // Check each strobed answer against the oldest one owed.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result %h arrived with no word outstanding", $realtime, result);
      end else begin
        answer_due = pending_answers.pop_front();
        if (result !== answer_due) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: result mismatch, expected %h got %h", $realtime, answer_due,
                     result);
        end
      end
    end
  end

  initial begin
    logic [W-1:0] batch_modulus [BATCHES];

    // Directed words, grouped by the modulus they need.
    add_directed(MODULUS_RESET, OP_POW, '0, '0, KNOWN, 32'd1);
    add_directed(MODULUS_RESET, OP_POW, 32'd5, '0, KNOWN, 32'd1);
    add_directed(MODULUS_RESET, OP_POW, '0, 32'd5, KNOWN, '0);
    add_directed(MODULUS_RESET, OP_POW, 32'd2, 32'd10, KNOWN, 32'd1024);
    add_directed(MODULUS_RESET, OP_POW, ALL_ONES, ALL_ONES, PREDICT, '0);
    add_directed(MODULUS_RESET, OP_DIV, 32'd10, '0, KNOWN, '0);
    add_directed(MODULUS_RESET, OP_DIV, 32'd7, MODULUS_RESET, KNOWN, '0);
    add_directed(MODULUS_RESET, OP_DIV, 32'd6, 32'd3, KNOWN, 32'd2);
    add_directed(MODULUS_RESET, OP_DIV, ALL_ONES, ALL_ONES, KNOWN, 32'd1);
    add_directed(MODULUS_RESET, OP_DIV, '0, 32'd5, KNOWN, '0);
    add_directed(32'd2, OP_POW, 32'd3, 32'd5, KNOWN, 32'd1);
    add_directed(32'd2, OP_POW, 32'd4, '0, KNOWN, 32'd1);
    add_directed(32'd2, OP_DIV, 32'd1, 32'd2, KNOWN, '0);
    add_directed(32'd2, OP_DIV, 32'd3, 32'd1, KNOWN, 32'd1);
    add_directed(32'd0, OP_POW, 32'd5, '0, KNOWN, '0);
    add_directed(32'd0, OP_DIV, 32'd5, 32'd3, KNOWN, '0);
    add_directed(32'd1, OP_POW, '0, '0, KNOWN, '0);
    add_directed(32'd1, OP_DIV, 32'd1, 32'd1, KNOWN, '0);
    add_directed(ALL_ONES, OP_POW, ALL_ONES, 32'd2, KNOWN, '0);
    add_directed(ALL_ONES, OP_POW, ALL_ONES - 1, ALL_ONES, KNOWN, ALL_ONES - 1);
    add_directed(ALL_ONES, OP_DIV, ALL_ONES - 1, ALL_ONES - 1, PREDICT, '0);
    add_directed(ALL_ONES, OP_DIV, 32'd12345, ALL_ONES, KNOWN, '0);
    add_directed(PRIME_TOP, OP_DIV, 32'd1, 32'd2, PREDICT, '0);
    add_directed(PRIME_TOP, OP_DIV, PRIME_TOP - 1, PRIME_TOP - 1, KNOWN, 32'd1);
    add_directed(PRIME_TOP, OP_POW, ALL_ONES, 32'h8000_0001, PREDICT, '0);

    // Moduli for the random batches, extremes and primes among them.
    batch_modulus[0] = MODULUS_RESET;
    batch_modulus[1] = 32'd2;
    batch_modulus[2] = PRIME_TOP;
    batch_modulus[3] = ALL_ONES;
    batch_modulus[4] = 32'd1000000007;
    batch_modulus[5] = 32'd3;
    batch_modulus[6] = $urandom | 32'h8000_0001;
    batch_modulus[7] = 32'd2147483647;
    batch_modulus[8] = 32'd65537;
    batch_modulus[9] = $urandom_range(65535, 5);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    idle_pct = 33;
    foreach (directed_words[i]) begin
      if (directed_words[i].modulus != modulus_shadow)
        write_modulus(directed_words[i].modulus);
      send_word(directed_words[i].op, directed_words[i].a, directed_words[i].b,
                directed_words[i].has_answer, directed_words[i].answer);
    end

    // Sender idles lightly, then heavily, then not at all. Every modulus
    // change drains the block first, so the sender also pauses for all answers.
    for (int bt = 0; bt < BATCHES; bt++) begin
      idle_pct = (bt < 4) ? 33 : (bt < 7) ? 84 : 0;
      write_modulus(batch_modulus[bt]);
      repeat (WORDS_PER_BATCH) send_random_word(batch_modulus[bt]);
    end

    settle_outstanding();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_answers.size() != 0) error_count++;
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Timeout that allows several times the worst-case run of all words.
  initial begin
    #150_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/mpd_pkg.sv
sv/mpd_modmul.sv
sv/modular_power_and_divide_top.sv
bench/tb_modular_power_and_divide_top.sv
